[hdl/lbra_pkg.sv]
// ----------------------------------------------------------------------------
// lbra_pkg
// Types and fixed constants shared by the loss based rate adjuster files.
// ----------------------------------------------------------------------------
package lbra_pkg;

   localparam int unsigned BW_W        = 32;
   localparam int unsigned THRESH_W    = 17;
   localparam int unsigned AVG_OUT_W   = 17;
   localparam int unsigned DECISION_W  = 2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   // bw * 11 needs four bits above the bandwidth
   localparam int unsigned INC_W       = BW_W + 4;
   // remainder of the serial divide by five or ten
   localparam int unsigned DREM_W      = 4;

   localparam logic [BW_W-1:0]     MAX_BW_RESET    = 32'hFFFF_FFFF;
   localparam logic [THRESH_W-1:0] LOW_THR_RESET   = 17'd1311;
   localparam logic [THRESH_W-1:0] HIGH_THR_RESET  = 17'd6554;

   localparam logic [DREM_W:0]     DIVISOR_FIVE    = 5'd5;
   localparam logic [DREM_W:0]     DIVISOR_TEN     = 5'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATIO,
      ST_DIV,
      ST_DECIDE,
      ST_MUL,
      ST_FINISH
   } state_type;

   typedef enum logic [DECISION_W-1:0] {
      DECISION_INCREASE = 2'd0,
      DECISION_HOLD     = 2'd1,
      DECISION_DECREASE = 2'd2
   } decision_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_BANDWIDTH       = 2'd0,
      CSR_LOW_LOSS_THRESHOLD  = 2'd1,
      CSR_HIGH_LOSS_THRESHOLD = 2'd2
   } csr_index_type;

endpackage

[hdl/lbra_req_if.sv]
// ----------------------------------------------------------------------------
// lbra_req_if
// Report channel: sent count, loss count and current bandwidth.
// ----------------------------------------------------------------------------
interface lbra_req_if;
   logic                        valid;
   logic                        ready;
   logic [lbra_pkg::BW_W-1:0]   sent_count;
   logic [lbra_pkg::BW_W-1:0]   loss_count;
   logic [lbra_pkg::BW_W-1:0]   bw_in_use;

   modport source (output valid, output sent_count, output loss_count,
                   output bw_in_use, input ready);
   modport sink   (input valid, input sent_count, input loss_count,
                   input bw_in_use, output ready);
endinterface

[hdl/lbra_rsp_if.sv]
// ----------------------------------------------------------------------------
// lbra_rsp_if
// Result channel: new bandwidth, loss average and decision flags.
// ----------------------------------------------------------------------------
interface lbra_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lbra_pkg::BW_W-1:0]         bw_adjusted;
   logic [lbra_pkg::AVG_OUT_W-1:0]    loss_average;
   logic [lbra_pkg::DECISION_W-1:0]   decision;
   logic                              clamped;
   logic                              no_traffic;

   modport source (output valid, output bw_adjusted, output loss_average,
                   output decision, output clamped, output no_traffic, input ready);
   modport sink   (input valid, input bw_adjusted, input loss_average,
                   input decision, input clamped, input no_traffic, output ready);
endinterface

[hdl/lbra_ratio_div.sv]
// ----------------------------------------------------------------------------
// lbra_ratio_div
// Radix-2 restoring divider for the loss ratio, one quotient bit per cycle,
// saturating at 1.0 when the dividend is not below the divisor.
// ----------------------------------------------------------------------------
module lbra_ratio_div #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lbra_pkg::BW_W-1:0]   dividend,
   input  logic [lbra_pkg::BW_W-1:0]   divisor,
   output logic                        done,
   output logic [FRAC_BITS:0]          quotient
);

   localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [lbra_pkg::BW_W-1:0]   rem_ff, rem_in;
   logic [lbra_pkg::BW_W-1:0]   dsr_ff, dsr_in;
   logic [FRAC_BITS:0]          quot_ff, quot_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [lbra_pkg::BW_W:0]     rem_dbl;
   logic [lbra_pkg::BW_W:0]     rem_diff;
   logic                        fits;

   always_comb begin
      rem_dbl  = {rem_ff, 1'b0};
      rem_diff = rem_dbl - {1'b0, dsr_ff};
      fits     = rem_dbl >= {1'b0, dsr_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;

      if (start) begin
         if (dividend >= divisor) begin
            quot_in = {1'b1, {FRAC_BITS{1'b0}}};
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = dividend;
            dsr_in  = divisor;
            quot_in = '0;
            cnt_in  = CNT_W'(FRAC_BITS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? rem_diff[lbra_pkg::BW_W-1:0] : rem_dbl[lbra_pkg::BW_W-1:0];
         quot_in = {quot_ff[FRAC_BITS-1:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

[hdl/loss_based_rate_adjuster.sv]
// ----------------------------------------------------------------------------
// loss_based_rate_adjuster
// Each report gives sent and lost packet counts with the bandwidth in use; the
// block forms the loss ratio (F = RATIO_FRAC_BITS fraction bits, saturating at
// 1.0), folds it into a running average floor((4*old + ratio)/5), and then
// raises the bandwidth by 10 percent, holds it, or scales it by (1 - average),
// limited by the csr maximum and, where that limit applies, BANDWIDTH_CEILING. One
// report is worked on at a time, all through one-bit-per-cycle shift units: the
// ratio divider (which saturates without shifting when the loss is not below
// the sent count), the divide by five, then the divide by ten for an increase
// or the shift-add multiply for a decrease, no shift unit for a hold, plus any
// wait for a previous result still held on rsp_chan.
// A zero sent count skips the ratio and average and needs only the decision.
// The next report is taken while the previous result still waits on rsp_chan.
// ----------------------------------------------------------------------------
module loss_based_rate_adjuster #(
   parameter logic [31:0]  BANDWIDTH_CEILING = 32'hFFFF_FFFF,
   parameter int unsigned  RATIO_FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   lbra_req_if.sink                            req_chan,
   lbra_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [lbra_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lbra_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int unsigned F      = RATIO_FRAC_BITS;
   localparam int unsigned AVG_W  = F + 1;
   localparam int unsigned SUM_W  = F + 3;
   localparam int unsigned KEEP_W = F + 1;
   localparam int unsigned SH_W   = lbra_pkg::BW_W + KEEP_W;
   localparam int unsigned CNT_W  = $clog2(SH_W + 1);
   localparam int unsigned CMP_W  = (AVG_W > lbra_pkg::THRESH_W) ? AVG_W : lbra_pkg::THRESH_W;
   localparam int unsigned NBW_W  = lbra_pkg::INC_W;
   localparam int unsigned BW_W   = lbra_pkg::BW_W;
   localparam int unsigned DREM_W = lbra_pkg::DREM_W;
   localparam logic [AVG_W-1:0] ONE_FIX = {1'b1, {F{1'b0}}};

   lbra_pkg::state_type     state_ff, state_in;
   lbra_pkg::decision_type  decision_ff, decision_in;

   logic [BW_W-1:0]                 max_bw_ff, max_bw_in;
   logic [lbra_pkg::THRESH_W-1:0]   low_thr_ff, low_thr_in;
   logic [lbra_pkg::THRESH_W-1:0]   high_thr_ff, high_thr_in;
   logic [AVG_W-1:0]                avg_ff, avg_in;
   logic [BW_W-1:0]                 bw_ff, bw_in;
   logic                            no_traffic_ff, no_traffic_in;
   logic                            div_ten_ff, div_ten_in;
   logic [SH_W-1:0]                 sh_ff, sh_in;
   logic [DREM_W-1:0]               drem_ff, drem_in;
   logic [CNT_W-1:0]                step_ff, step_in;
   logic [NBW_W-1:0]                nbw_ff, nbw_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [BW_W-1:0]                 rsp_nbw_ff, rsp_nbw_in;
   logic [lbra_pkg::AVG_OUT_W-1:0]  rsp_avg_ff, rsp_avg_in;
   lbra_pkg::decision_type          rsp_decision_ff, rsp_decision_in;
   logic                            rsp_clamped_ff, rsp_clamped_in;
   logic                            rsp_no_traffic_ff, rsp_no_traffic_in;

   logic                            accept;
   logic                            div_start;
   logic                            div_done;
   logic [AVG_W-1:0]                ratio;

   logic [DREM_W:0]                 div_part;
   logic [DREM_W:0]                 divisor_k;
   logic [DREM_W:0]                 div_diff;
   logic                            div_fit;
   logic [SH_W-1:0]                 sh_div_next;
   logic [BW_W:0]                   mul_sum;
   logic [SH_W-1:0]                 sh_mul_next;
   logic [SUM_W-1:0]                avg_sum;
   logic [NBW_W-1:0]                bw_ext;
   logic [NBW_W-1:0]                bw11;
   logic [KEEP_W-1:0]               keep;
   logic [CMP_W-1:0]                avg_cmp, low_cmp, high_cmp;
   logic                            last_step;
   logic                            out_free;
   logic                            clamp;
   logic [BW_W-1:0]                 limit;

   assign accept          = req_chan.valid && req_chan.ready;
   assign req_chan.ready  = (state_ff == lbra_pkg::ST_IDLE);
   assign div_start       = accept && (req_chan.sent_count != '0);

   lbra_ratio_div #(
      .FRAC_BITS (F)
   ) u_ratio_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_chan.loss_count),
      .divisor  (req_chan.sent_count),
      .done     (div_done),
      .quotient (ratio)
   );

   // csr writes
   always_comb begin
      max_bw_in   = max_bw_ff;
      low_thr_in  = low_thr_ff;
      high_thr_in = high_thr_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            lbra_pkg::CSR_MAX_BANDWIDTH:       max_bw_in   = csr_write_data[BW_W-1:0];
            lbra_pkg::CSR_LOW_LOSS_THRESHOLD:  low_thr_in  = csr_write_data[lbra_pkg::THRESH_W-1:0];
            lbra_pkg::CSR_HIGH_LOSS_THRESHOLD: high_thr_in = csr_write_data[lbra_pkg::THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // shared serial datapath
   always_comb begin
      // divide by five or ten, msb first
      divisor_k   = div_ten_ff ? lbra_pkg::DIVISOR_TEN : lbra_pkg::DIVISOR_FIVE;
      div_part    = {drem_ff, sh_ff[SH_W-1]};
      div_fit     = div_part >= divisor_k;
      div_diff    = div_part - divisor_k;
      sh_div_next = {sh_ff[SH_W-2:0], div_fit};

      // shift-add multiply, multiplier in the low bits, lsb first
      mul_sum     = {1'b0, sh_ff[SH_W-1 -: BW_W]} + (sh_ff[0] ? {1'b0, bw_ff} : '0);
      sh_mul_next = {mul_sum, sh_ff[KEEP_W-1:1]};

      avg_sum  = {avg_ff, 2'b00} + SUM_W'(ratio);
      bw_ext   = NBW_W'(bw_ff);
      bw11     = (bw_ext << 3) + (bw_ext << 1) + bw_ext;
      keep     = (avg_ff >= ONE_FIX) ? '0 : (ONE_FIX - avg_ff);

      avg_cmp  = CMP_W'(avg_ff);
      low_cmp  = CMP_W'(low_thr_ff);
      high_cmp = CMP_W'(high_thr_ff);

      last_step = (step_ff == CNT_W'(1));
      out_free  = !rsp_valid_ff || rsp_chan.ready;
      clamp     = nbw_ff >= NBW_W'(max_bw_ff);
      limit     = (max_bw_ff >= BANDWIDTH_CEILING) ? BANDWIDTH_CEILING : max_bw_ff;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      decision_in   = decision_ff;
      avg_in        = avg_ff;
      bw_in         = bw_ff;
      no_traffic_in = no_traffic_ff;
      div_ten_in    = div_ten_ff;
      sh_in         = sh_ff;
      drem_in       = drem_ff;
      step_in       = step_ff;
      nbw_in        = nbw_ff;

      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      rsp_nbw_in        = rsp_nbw_ff;
      rsp_avg_in        = rsp_avg_ff;
      rsp_decision_in   = rsp_decision_ff;
      rsp_clamped_in    = rsp_clamped_ff;
      rsp_no_traffic_in = rsp_no_traffic_ff;

      unique case (state_ff)
         lbra_pkg::ST_IDLE: begin
            if (accept) begin
               bw_in         = req_chan.bw_in_use;
               no_traffic_in = (req_chan.sent_count == '0);
               state_in      = div_start ? lbra_pkg::ST_RATIO : lbra_pkg::ST_DECIDE;
            end
         end
         lbra_pkg::ST_RATIO: begin
            if (div_done) begin
               sh_in      = {avg_sum, {(SH_W - SUM_W){1'b0}}};
               drem_in    = '0;
               step_in    = CNT_W'(SUM_W);
               div_ten_in = 1'b0;
               state_in   = lbra_pkg::ST_DIV;
            end
         end
         lbra_pkg::ST_DIV: begin
            sh_in   = sh_div_next;
            drem_in = div_fit ? div_diff[DREM_W-1:0] : div_part[DREM_W-1:0];
            step_in = step_ff - CNT_W'(1);
            if (last_step) begin
               if (div_ten_ff) begin
                  nbw_in   = sh_div_next[NBW_W-1:0];
                  state_in = lbra_pkg::ST_FINISH;
               end else begin
                  avg_in   = sh_div_next[AVG_W-1:0];
                  state_in = lbra_pkg::ST_DECIDE;
               end
            end
         end
         lbra_pkg::ST_DECIDE: begin
            priority if (avg_cmp <= low_cmp) begin
               decision_in = lbra_pkg::DECISION_INCREASE;
               sh_in       = {bw11, {(SH_W - NBW_W){1'b0}}};
               drem_in     = '0;
               step_in     = CNT_W'(NBW_W);
               div_ten_in  = 1'b1;
               state_in    = lbra_pkg::ST_DIV;
            end else if (avg_cmp < high_cmp) begin
               decision_in = lbra_pkg::DECISION_HOLD;
               nbw_in      = bw_ext;
               state_in    = lbra_pkg::ST_FINISH;
            end else begin
               decision_in = lbra_pkg::DECISION_DECREASE;
               sh_in       = {{BW_W{1'b0}}, keep};
               step_in     = CNT_W'(KEEP_W);
               state_in    = lbra_pkg::ST_MUL;
            end
         end
         lbra_pkg::ST_MUL: begin
            sh_in   = sh_mul_next;
            step_in = step_ff - CNT_W'(1);
            if (last_step) begin
               nbw_in   = NBW_W'(sh_mul_next[SH_W-1:F]);
               state_in = lbra_pkg::ST_FINISH;
            end
         end
         lbra_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_nbw_in        = clamp ? limit : nbw_ff[BW_W-1:0];
               rsp_avg_in        = lbra_pkg::AVG_OUT_W'(avg_ff);
               rsp_decision_in   = decision_ff;
               rsp_clamped_in    = clamp;
               rsp_no_traffic_in = no_traffic_ff;
               state_in          = lbra_pkg::ST_IDLE;
            end
         end
         default: state_in = lbra_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbra_pkg::ST_IDLE;
         max_bw_ff    <= lbra_pkg::MAX_BW_RESET;
         low_thr_ff   <= lbra_pkg::LOW_THR_RESET;
         high_thr_ff  <= lbra_pkg::HIGH_THR_RESET;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_bw_ff    <= max_bw_in;
         low_thr_ff   <= low_thr_in;
         high_thr_ff  <= high_thr_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      decision_ff       <= decision_in;
      bw_ff             <= bw_in;
      no_traffic_ff     <= no_traffic_in;
      div_ten_ff        <= div_ten_in;
      sh_ff             <= sh_in;
      drem_ff           <= drem_in;
      step_ff           <= step_in;
      nbw_ff            <= nbw_in;
      rsp_nbw_ff        <= rsp_nbw_in;
      rsp_avg_ff        <= rsp_avg_in;
      rsp_decision_ff   <= rsp_decision_in;
      rsp_clamped_ff    <= rsp_clamped_in;
      rsp_no_traffic_ff <= rsp_no_traffic_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.bw_adjusted   = rsp_nbw_ff;
   assign rsp_chan.loss_average  = rsp_avg_ff;
   assign rsp_chan.decision      = rsp_decision_ff;
   assign rsp_chan.clamped       = rsp_clamped_ff;
   assign rsp_chan.no_traffic    = rsp_no_traffic_ff;

   // a report without traffic goes straight to the decision and keeps the average
   a_no_traffic_keeps_avg: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.sent_count == '0)) |=>
         (state_ff == lbra_pkg::ST_DECIDE) && $stable(avg_ff))
      else $error("average moved on a report without traffic");

   a_avg_bounded: assert property (@(posedge clock) disable iff (reset)
      avg_ff <= ONE_FIX)
      else $error("loss average above 1.0");

   a_div_done_in_ratio: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == lbra_pkg::ST_RATIO))
      else $error("ratio divider finished outside the ratio wait");

   a_step_live: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == lbra_pkg::ST_DIV) || (state_ff == lbra_pkg::ST_MUL)) |-> (step_ff != '0))
      else $error("serial step counter ran out");

endmodule

[verif/lbra_tb_pkg.sv]
// ----------------------------------------------------------------------------
// lbra_tb_pkg
// Beat types and the scoreboard for the loss based rate adjuster bench. The
// scoreboard keeps its own copy of the csr values and of the loss average,
// works out the adjustment for each accepted report and checks result beats
// in order against it.
// ----------------------------------------------------------------------------
package lbra_tb_pkg;
   import lbra_pkg::*;

   localparam int unsigned         RATIO_FRAC = 16;
   localparam logic [BW_W-1:0]     BW_CEILING = 32'hFFFF_FFFF;
   localparam logic [THRESH_W-1:0] RATIO_ONE  = THRESH_W'(1) << RATIO_FRAC;

   typedef struct packed {
      logic [BW_W-1:0] sent_count;
      logic [BW_W-1:0] loss_count;
      logic [BW_W-1:0] bw_in_use;
   } report_type;

   typedef struct packed {
      logic [BW_W-1:0]      bw_adjusted;
      logic [AVG_OUT_W-1:0] loss_average;
      decision_type         decision;
      logic                 clamped;
      logic                 no_traffic;
   } adjustment_type;

   class bandwidth_scoreboard;
      logic [BW_W-1:0]      bw_limit;
      logic [THRESH_W-1:0]  low_threshold;
      logic [THRESH_W-1:0]  high_threshold;
      logic [AVG_OUT_W-1:0] loss_avg;
      adjustment_type       expected_adjustments[$];
      int unsigned          error_count;

      function new();
         bw_limit       = MAX_BW_RESET;
         low_threshold  = LOW_THR_RESET;
         high_threshold = HIGH_THR_RESET;
         loss_avg       = '0;
         error_count    = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_MAX_BANDWIDTH:       bw_limit       = data[BW_W-1:0];
            CSR_LOW_LOSS_THRESHOLD:  low_threshold  = data[THRESH_W-1:0];
            CSR_HIGH_LOSS_THRESHOLD: high_threshold = data[THRESH_W-1:0];
            default: ;
         endcase
      endfunction

      function adjustment_type predict_adjustment(report_type rep);
         adjustment_type adj;
         logic [63:0] ratio;
         logic [63:0] keep;
         logic [63:0] bw_next;
         adj = '0;
         adj.no_traffic = (rep.sent_count == '0);
         // zero sent count keeps the average as it is
         if (!adj.no_traffic) begin
            if (rep.loss_count >= rep.sent_count) begin
               ratio = 64'(RATIO_ONE);
            end else begin
               ratio = (64'(rep.loss_count) << RATIO_FRAC) / 64'(rep.sent_count);
            end
            loss_avg = AVG_OUT_W'((4 * 64'(loss_avg) + ratio) / 5);
         end
         adj.loss_average = loss_avg;
         if (loss_avg <= low_threshold) begin
            adj.decision = DECISION_INCREASE;
            bw_next = 64'(rep.bw_in_use) * 11 / 10;
         end else if (loss_avg < high_threshold) begin
            adj.decision = DECISION_HOLD;
            bw_next = 64'(rep.bw_in_use);
         end else begin
            adj.decision = DECISION_DECREASE;
            keep = (loss_avg >= RATIO_ONE) ? 64'd0 : 64'(RATIO_ONE - loss_avg);
            bw_next = (64'(rep.bw_in_use) * keep) >> RATIO_FRAC;
         end
         // ceiling only applies inside the limit branch
         if (bw_next >= 64'(bw_limit)) begin
            bw_next = 64'(bw_limit);
            if (bw_next >= 64'(BW_CEILING)) begin
               bw_next = 64'(BW_CEILING);
            end
            adj.clamped = 1'b1;
         end
         adj.bw_adjusted = bw_next[BW_W-1:0];
         return adj;
      endfunction

      function void note_report(report_type rep);
         expected_adjustments.push_back(predict_adjustment(rep));
      endfunction

      function int unsigned pending();
         return expected_adjustments.size();
      endfunction

      function void flag_field(string field, logic [BW_W-1:0] want, logic [BW_W-1:0] got);
         if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, field, want, got);
         end
      endfunction

      function void check_result(adjustment_type got);
         adjustment_type want;
         if (expected_adjustments.size() == 0) begin
            error_count++;
            $display("%0t: result beat with nothing outstanding: expected none, actual %p",
                     $time, got);
            return;
         end
         want = expected_adjustments.pop_front();
         flag_field("bw_adjusted", want.bw_adjusted, got.bw_adjusted);
         flag_field("loss_average", BW_W'(want.loss_average), BW_W'(got.loss_average));
         flag_field("decision", BW_W'(want.decision), BW_W'(got.decision));
         flag_field("clamped", BW_W'(want.clamped), BW_W'(got.clamped));
         flag_field("no_traffic", BW_W'(want.no_traffic), BW_W'(got.no_traffic));
      endfunction

      function void close_out();
         if (expected_adjustments.size() != 0) begin
            error_count += expected_adjustments.size();
            $display("%0t: %0d results expected, actual none", $time,
                     expected_adjustments.size());
         end
      endfunction
   endclass

endpackage

[verif/tb_loss_based_rate_adjuster.sv]
// ----------------------------------------------------------------------------
// tb_loss_based_rate_adjuster
// Drives loss reports into the rate adjuster with random gaps on both channels
// and checks every result beat against the scoreboard prediction. A directed
// set covers idle intervals, saturating loss, clamping and threshold corners,
// then random phases run under several csr settings.
// ----------------------------------------------------------------------------
module tb_loss_based_rate_adjuster;
   import lbra_pkg::*;
   import lbra_tb_pkg::*;

   localparam int unsigned            SETTLE_CYCLES   = 100;
   localparam int unsigned            WATCHDOG_LIMIT  = 2000;
   localparam int unsigned            ITEMS_PER_PHASE = 200;
   localparam int unsigned            PHASE_COUNT     = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_SPARE = 2'd3;
   localparam logic [BW_W-1:0]        BW_FULL         = 32'hFFFF_FFFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   bit                     sender_steady = 1'b0;
   bit                     receiver_steady = 1'b0;
   int unsigned            quiet_cycles = 0;

   bandwidth_scoreboard rate_sb = new();

   lbra_req_if req_if();
   lbra_rsp_if rsp_if();

   loss_based_rate_adjuster #(
      .BANDWIDTH_CEILING(BW_CEILING),
      .RATIO_FRAC_BITS(RATIO_FRAC)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      rate_sb.write_register(index, data);
      @(posedge clock);
   endtask

   // called right after an edge; leaves valid high so the next beat can follow
   task automatic send_report(input logic [BW_W-1:0] sent, input logic [BW_W-1:0] loss,
                              input logic [BW_W-1:0] bw);
      int unsigned gap;
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 31) == 0) begin
         sender_steady = !sender_steady;
      end
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.sent_count <= sent;
      req_if.loss_count <= loss;
      req_if.bw_in_use  <= bw;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // wait until every outstanding result is back, optionally let the block settle
   task automatic quiesce(input bit settle);
      req_if.valid <= 1'b0;
      do @(posedge clock); while (rate_sb.pending() != 0);
      if (settle) begin
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : beat_monitor
      adjustment_type seen;
      report_type     taken;
      if (!reset) begin
         // check before noting so a same-edge report cannot mask a stray result
         if (rsp_if.valid && rsp_if.ready) begin
            seen.bw_adjusted  = rsp_if.bw_adjusted;
            seen.loss_average = rsp_if.loss_average;
            seen.decision     = decision_type'(rsp_if.decision);
            seen.clamped      = rsp_if.clamped;
            seen.no_traffic   = rsp_if.no_traffic;
            rate_sb.check_result(seen);
         end
         if (req_if.valid && req_if.ready) begin
            taken.sent_count = req_if.sent_count;
            taken.loss_count = req_if.loss_count;
            taken.bw_in_use  = req_if.bw_in_use;
            rate_sb.note_report(taken);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** loss_based_rate_adjuster: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      int unsigned stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = receiver_steady ? 0 : $urandom_range(0, 6);
         if ($urandom_range(0, 31) == 0) begin
            receiver_steady = !receiver_steady;
         end
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin
      logic [BW_W-1:0]       sent;
      logic [BW_W-1:0]       loss;
      logic [BW_W-1:0]       bw;
      logic [CSR_DATA_W-1:0] low_data;
      logic [CSR_DATA_W-1:0] high_data;
      logic [CSR_DATA_W-1:0] max_data;
      int unsigned           kind;

      req_if.valid      <= 1'b0;
      req_if.sent_count <= '0;
      req_if.loss_count <= '0;
      req_if.bw_in_use  <= '0;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_MAX_BANDWIDTH;
      csr_write_data    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset thresholds: idle intervals, saturating loss, overflowing increase
      send_report('0, '0, 32'd1000);
      send_report('0, BW_FULL, BW_FULL);
      send_report(BW_FULL, '0, '0);
      send_report(32'd1, 32'd1, BW_FULL);
      send_report(32'd1, BW_FULL, 32'h8000_0000);
      send_report(BW_FULL, 32'hFFFF_FFFE, 32'h1234_5678);
      send_report('0, 32'd5, 32'h0000_FFFF);
      send_report(32'd3, 32'd1, 32'd777);
      repeat (3) send_report(BW_FULL, '0, 32'd5000);

      // wide low threshold, result landing exactly on the maximum
      quiesce(1'b1);
      write_csr(CSR_MAX_BANDWIDTH, 32'd1100);
      write_csr(CSR_LOW_LOSS_THRESHOLD, 32'hFFFF_FFFF);
      write_csr(CSR_HIGH_LOSS_THRESHOLD, 32'h0001_0000);
      send_report(32'd1, '0, 32'd1000);
      send_report(32'd1, '0, 32'd999);

      // empty hold band with a zero maximum
      quiesce(1'b1);
      write_csr(CSR_MAX_BANDWIDTH, '0);
      write_csr(CSR_LOW_LOSS_THRESHOLD, '0);
      write_csr(CSR_HIGH_LOSS_THRESHOLD, '0);
      write_csr(CSR_INDEX_SPARE, 32'hDEAD_BEEF);
      send_report(32'd7, 32'd3, 32'd5000);
      send_report('0, '0, '0);

      // everything above zero holds
      quiesce(1'b1);
      write_csr(CSR_MAX_BANDWIDTH, BW_FULL);
      write_csr(CSR_LOW_LOSS_THRESHOLD, '0);
      write_csr(CSR_HIGH_LOSS_THRESHOLD, 32'h0001_FFFF);
      send_report(32'd5, 32'd2, BW_FULL);
      send_report(32'd5, 32'd2, 32'd42);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         quiesce(1'b1);
         case (phase % 4)
            0: begin
               low_data  = 32'(LOW_THR_RESET);
               high_data = 32'(HIGH_THR_RESET);
               max_data  = MAX_BW_RESET;
            end
            1: begin
               low_data  = $urandom_range(0, 8000);
               high_data = low_data + $urandom_range(1, 30000);
               max_data  = $urandom;
            end
            2: begin
               high_data = $urandom_range(0, 20000);
               low_data  = high_data + $urandom_range(0, 20000);
               max_data  = $urandom_range(0, 1 << 20);
            end
            default: begin
               low_data  = $urandom;
               high_data = $urandom;
               max_data  = $urandom_range(0, 1) ? BW_FULL : '0;
            end
         endcase
         write_csr(CSR_MAX_BANDWIDTH, max_data);
         write_csr(CSR_LOW_LOSS_THRESHOLD, low_data);
         write_csr(CSR_HIGH_LOSS_THRESHOLD, high_data);
         write_csr(CSR_INDEX_SPARE, $urandom);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 63) == 0) begin
               quiesce(1'b0);
            end
            kind = $urandom_range(0, 15);
            sent = $urandom >> $urandom_range(0, 28);
            if (sent == '0) begin
               sent = 32'd1;
            end
            // mostly light loss so the average moves around the thresholds
            case (kind)
               0: begin
                  sent = '0;
                  loss = $urandom;
               end
               1: loss = $urandom;
               2: begin
                  sent = $urandom_range(1, 8);
                  loss = $urandom_range(0, 10);
               end
               3, 4, 5, 6, 7, 8, 9: loss = sent >> $urandom_range(5, 16);
               10, 11, 12, 13: loss = sent >> $urandom_range(1, 4);
               default: loss = sent - (sent >> $urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 3))
               0: bw = $urandom;
               1: bw = $urandom_range(0, 5000);
               2: bw = BW_FULL - $urandom_range(0, 1000);
               default: bw = $urandom >> $urandom_range(0, 31);
            endcase
            send_report(sent, loss, bw);
         end
      end

      quiesce(1'b1);
      rate_sb.close_out();
      if (rate_sb.error_count == 0) begin
         $display("** loss_based_rate_adjuster: PASSED **");
      end else begin
         $display("** loss_based_rate_adjuster: FAILED **");
      end
      $finish;
   end

endmodule

[loss_based_rate_adjuster.f]
hdl/lbra_pkg.sv
hdl/lbra_req_if.sv
hdl/lbra_rsp_if.sv
hdl/lbra_ratio_div.sv
hdl/loss_based_rate_adjuster.sv
verif/lbra_tb_pkg.sv
verif/tb_loss_based_rate_adjuster.sv
